@@ design/breakpoint_envelope_interp_macros.svh @@
// Assertion macros used by the checker file
`ifndef BREAKPOINT_ENVELOPE_INTERP_MACROS_SVH
`define BREAKPOINT_ENVELOPE_INTERP_MACROS_SVH

// Check an implication on every clock edge outside reset
`define BEI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the cycle after the antecedent
`define BEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bei_pkg.sv @@
package bei_pkg;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_DECREASING = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_EMPTY      = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        time_in;
        logic signed [31:0] value_in;
    } bei_in_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [1:0]         status;
    } bei_out_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture request beat
        logic write_pt;   // append point to table
        logic clear;      // empty the table
        logic rd_capture; // take read data as right point
        logic shift_lr;   // right point becomes left, advance index
        logic mul_start;  // compute product
        logic div_start;  // start divider
        logic div_step;   // one restoring step
        logic finish;     // form result
        logic [1:0] mode; // result selection
    } bei_cmd_t;

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_LEFT = 2'd1;
    localparam logic [1:0] MODE_RIGHT = 2'd2;
    localparam logic [1:0] MODE_INTERP = 2'd3;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic decreasing;
        logic idx_last;     // scan index is the last point
        logic below_first;  // query before first point (valid after first capture)
        logic hit;          // query <= right point time
        logic equal_times;  // left and right share a time
        logic div_done;
    } bei_stat_t;

endpackage

@@ design/bei_ram.sv @@
module bei_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/bei_datapath.sv @@
module bei_datapath import bei_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  bei_in_t   req,
    input  bei_cmd_t  cmd,
    output bei_stat_t stat,
    output bei_out_t  result
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0]      count_reg;
    logic [31:0]        last_time_reg;
    logic [1:0]         req_type_reg;
    logic [31:0]        qtime_reg;
    logic [31:0]        vin_reg;
    logic [AW-1:0]      idx_reg;
    logic [31:0]        tl_reg, tr_reg;
    logic signed [31:0] vl_reg, vr_reg;
    logic               first_reg;
    logic               below_reg;
    logic [63:0]        num_reg;   // product, then shifts out into the remainder
    logic [31:0]        den_reg;
    logic [63:0]        quo_reg;
    logic [32:0]        rem_reg;
    logic [6:0]         step_reg;
    logic               neg_reg;
    logic [1:0]         load_status_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] value_reg;

    logic [31:0] t_rd, v_rd;
    logic [AW-1:0] raddr;

    assign raddr = idx_reg;

    bei_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_time_ram (
        .clk(clk), .we(cmd.write_pt), .waddr(count_reg[AW-1:0]),
        .wdata(qtime_reg), .raddr(raddr), .rdata(t_rd));

    bei_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_value_ram (
        .clk(clk), .we(cmd.write_pt), .waddr(count_reg[AW-1:0]),
        .wdata(vin_reg), .raddr(raddr), .rdata(v_rd));

    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [32:0]        rem_try;
    logic [63:0]        q_sel;
    logic signed [33:0] interp;

    assign diff    = 33'(vr_reg) - 33'(vl_reg);
    assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
    assign rem_try = {rem_reg[31:0], num_reg[63]} - {1'b0, den_reg};
    assign q_sel   = quo_reg;
    assign interp  = neg_reg ? (34'(vl_reg) - 34'(q_sel[32:0]))
                             : (34'(vl_reg) + 34'(q_sel[32:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_time_reg <= '0;
        end
        else if (cmd.clear)
        begin
            count_reg     <= '0;
            last_time_reg <= '0;
        end
        else if (cmd.write_pt)
        begin
            count_reg     <= count_reg + CW'(1);
            last_time_reg <= qtime_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_type_reg <= req.req_type;
            qtime_reg    <= req.time_in;
            vin_reg      <= req.value_in;
            idx_reg      <= '0;
            first_reg    <= 1'b1;
            // Load verdict from the table state before any write
            if (count_reg == CW'(MAX_POINTS))
                load_status_reg <= ST_FULL;
            else if (req.time_in < last_time_reg)
                load_status_reg <= ST_DECREASING;
            else
                load_status_reg <= ST_OK;
        end
        if (cmd.rd_capture)
        begin
            tr_reg <= t_rd;
            vr_reg <= v_rd;
            if (first_reg)
            begin
                below_reg <= qtime_reg < t_rd;
                first_reg <= 1'b0;
            end
        end
        if (cmd.shift_lr)
        begin
            tl_reg  <= tr_reg;
            vl_reg  <= vr_reg;
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.mul_start)
        begin
            // 33x32 magnitude times offset, one product
            num_reg <= 64'(mag) * 64'(qtime_reg - tl_reg);
            den_reg <= tr_reg - tl_reg;
            neg_reg <= diff[32];
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_try[32])
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], num_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            num_reg  <= {num_reg[62:0], 1'b0};
            step_reg <= step_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= ST_OK;
            value_reg  <= '0;
            case (req_type_reg)
                REQ_LOAD:
                begin
                    status_reg <= load_status_reg;
                end
                REQ_QUERY:
                begin
                    case (cmd.mode)
                        MODE_ZERO:   status_reg <= ST_EMPTY;
                        MODE_LEFT:   value_reg  <= vl_reg;
                        MODE_RIGHT:  value_reg  <= vr_reg;
                        MODE_INTERP: value_reg  <= interp[31:0];
                        default:     value_reg  <= '0;
                    endcase
                end
                default: status_reg <= ST_OK;
            endcase
        end
    end

    assign stat.full        = count_reg == CW'(MAX_POINTS);
    assign stat.empty       = count_reg == '0;
    assign stat.decreasing  = qtime_reg < last_time_reg;
    assign stat.idx_last    = CW'(idx_reg) == count_reg - CW'(1);
    assign stat.below_first = below_reg;
    assign stat.hit         = qtime_reg <= tr_reg;
    assign stat.equal_times = tr_reg == tl_reg;
    assign stat.div_done    = step_reg == 7'd64;

    assign result.value_out = value_reg;
    assign result.status    = status_reg;

endmodule

@@ design/bei_ctrl.sv @@
module bei_ctrl import bei_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] req_type,
    input  bei_stat_t stat,
    output bei_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD, S_CAP, S_CHECK, S_MUL, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] rt_reg;
    logic [1:0] mode_reg;
    logic       done_reg;
    // Scan index zero is the first point
    logic       at_first_reg;
    logic       chk_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rt_reg       <= REQ_LOAD;
            mode_reg     <= MODE_ZERO;
            done_reg     <= 1'b0;
            at_first_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    at_first_reg <= 1'b1;
                    if (start)
                    begin
                        rt_reg    <= req_type;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (rt_reg == REQ_QUERY && !stat.empty)
                        state_reg <= S_RD;
                    else
                    begin
                        mode_reg  <= MODE_ZERO;
                        state_reg <= S_FIN;
                    end
                end
                S_RD:  state_reg <= S_CAP;
                S_CAP: state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (stat.below_first)
                    begin
                        mode_reg  <= MODE_RIGHT;
                        state_reg <= S_FIN;
                    end
                    else if (stat.idx_last && !(stat.hit && !at_first_reg))
                    begin
                        mode_reg  <= MODE_RIGHT;
                        state_reg <= S_FIN;
                    end
                    else if (!at_first_reg && stat.hit)
                    begin
                        if (stat.equal_times)
                        begin
                            mode_reg  <= MODE_RIGHT;
                            state_reg <= S_FIN;
                        end
                        else
                            state_reg <= S_MUL;
                    end
                    else
                    begin
                        at_first_reg <= 1'b0;
                        state_reg    <= S_RD;
                    end
                end
                S_MUL: state_reg <= S_DIV;
                S_DIV:
                    if (stat.div_done)
                    begin
                        mode_reg  <= MODE_INTERP;
                        state_reg <= S_FIN;
                    end
                S_FIN: state_reg <= S_OUT;
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign chk_adv = (state_reg == S_CHECK) && !stat.below_first
                     && !(stat.idx_last && !(stat.hit && !at_first_reg))
                     && !(!at_first_reg && stat.hit);

    always_comb
    begin
        cmd            = '0;
        cmd.latch      = (state_reg == S_IDLE) && start;
        cmd.write_pt   = (state_reg == S_DECODE) && (rt_reg == REQ_LOAD)
                         && !stat.full && !stat.decreasing;
        cmd.clear      = (state_reg == S_DECODE) && (rt_reg == REQ_CLEAR);
        cmd.rd_capture = state_reg == S_CAP;
        // Left point follows the right one each time the scan moves on,
        // and also when the query falls before the first point
        cmd.shift_lr   = chk_adv || ((state_reg == S_CHECK) && stat.below_first);
        cmd.mul_start  = (state_reg == S_CHECK) && !stat.below_first && !at_first_reg
                         && stat.hit && !stat.equal_times;
        cmd.div_start  = state_reg == S_MUL;
        cmd.div_step   = (state_reg == S_DIV) && !stat.div_done;
        cmd.finish     = state_reg == S_FIN;
        cmd.mode       = mode_reg;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

endmodule

@@ design/breakpoint_envelope_interp.sv @@
// Channel   Handshake        Payload
// request   start / busy     req (bei_in_t: req_type, time_in, value_in)
// result    done strobe      rsp (bei_out_t: value_out, status)
//
// Loads and clears go from start through decode, finish and output states to done;
// a query also reads, captures and checks each point scanned and, when it interpolates,
// takes a multiply step, 64 restoring divider steps and an exit step.
// Reset clears the point count and last time; table contents stay undefined.
// busy is high from the accepted beat until the cycle that carries done; the
// receiver cannot stall, so done is high for one cycle and the result is gone afterwards.
module breakpoint_envelope_interp import bei_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bei_in_t  req,
    output logic     done,
    output bei_out_t rsp
);

    bei_cmd_t  cmd;
    bei_stat_t stat;
    bei_out_t  dp_result;

    bei_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req_type(req.req_type),
        .stat(stat), .cmd(cmd), .busy(busy), .done(done));

    bei_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .stat(stat),
        .result(dp_result));

    // Drive the result only during the done strobe
    always_comb
    begin
        rsp = dp_result;
        if (!done)
        begin
            rsp = '0;
        end
    end

endmodule

@@ design/bei_checker.sv @@
`include "breakpoint_envelope_interp_macros.svh"
module bei_checker import bei_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input bei_in_t  req,
    input logic     done,
    input bei_out_t rsp
);

    `BEI_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted beat did not raise busy")
    `BEI_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held longer than one cycle")
    `BEI_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "result while a beat is still in flight")
    `BEI_ASSERT_IMPL(a_empty_zero, clk, rst_n, done && rsp.status == ST_EMPTY, rsp.value_out == 0, "empty status with nonzero value")

endmodule

bind breakpoint_envelope_interp bei_checker u_bei_checker (.*);
